// ----- rtl/mcct_pkg.sv -----
package mcct_pkg;

    localparam int PULSES_PER_BEAT_DEF = 24;

    localparam logic [7:0] STATUS_START = 8'hFA;
    localparam logic [7:0] STATUS_STOP  = 8'hFC;
    localparam logic [7:0] STATUS_CLOCK = 8'hF8;

    // 60e9 ns per minute times 256 for the Q8 tempo
    localparam logic [63:0] NUM_SCALE = 64'd15360000000000;
    localparam logic [23:0] TEMPO_MAX = 24'hFFFFFF;
    localparam int          TEMPO_W   = 24;
    localparam int          LARGE_BIT = 56;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [62:0] time_ns;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        playing;
        logic        tempo_known;
        logic [23:0] tempo_q8;
        logic [4:0]  tick_position;
        logic [16:0] beat_distance_q16;
    } result_t;

    typedef struct packed {
        logic        done;
        logic        update;
        logic [23:0] tempo;
    } mcct_tempo_t;

endpackage

// ----- rtl/mcct_ram.sv -----
module mcct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/mcct_tempo_unit.sv -----
module mcct_tempo_unit #(
    parameter int PULSES_PER_BEAT = mcct_pkg::PULSES_PER_BEAT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [63:0]                        rd_data,
    input  logic                               rd_valid,
    output logic [$clog2(PULSES_PER_BEAT)-1:0] rd_addr,
    output mcct_pkg::mcct_tempo_t              status
);

    import mcct_pkg::*;

    localparam int AW    = $clog2(PULSES_PER_BEAT);
    localparam int CW    = $clog2(PULSES_PER_BEAT + 1);
    localparam int SUM_W = 64 + $clog2(PULSES_PER_BEAT);
    localparam int NUM_W = $clog2(NUM_SCALE * PULSES_PER_BEAT + 1);
    localparam int DEN_W = LARGE_BIT + CW;
    localparam int SW    = $clog2(TEMPO_W);

    typedef enum logic [5:0] {
        U_IDLE  = 6'b000001,
        U_SUM   = 6'b000010,
        U_CHECK = 6'b000100,
        U_MULT  = 6'b001000,
        U_PRE   = 6'b010000,
        U_DIV   = 6'b100000
    } ustate_t;

    ustate_t             state_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [TEMPO_W-1:0]  quo_reg;
    logic [SW-1:0]       step_reg;
    mcct_tempo_t         status_reg;
    mcct_tempo_t         status_next;

    logic [63:0]         entry;
    logic [DEN_W:0]      shifted;
    logic [SUM_W-1:0]    alu_a;
    logic [SUM_W-1:0]    alu_b;
    logic                alu_sub;
    logic [SUM_W-1:0]    alu_res;
    logic                alu_ge;
    logic                sum_neg;
    logic                sum_zero;
    logic                sum_large;

    assign entry   = rd_valid ? rd_data : 64'd0;
    assign shifted = {rem_reg, quo_reg[TEMPO_W-1]};
    assign rd_addr = (cnt_reg < CW'(PULSES_PER_BEAT)) ? cnt_reg[AW-1:0] : '0;
    assign status  = status_reg;

    // shared adder: running sum during the sweep, trial subtract during division
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            U_SUM:
            begin
                alu_a = sum_reg;
                alu_b = {{(SUM_W-64){entry[63]}}, entry};
            end
            U_PRE:
            begin
                alu_a   = SUM_W'(num_reg[NUM_W-1:TEMPO_W]);
                alu_b   = SUM_W'(den_reg);
                alu_sub = 1'b1;
            end
            U_DIV:
            begin
                alu_a   = SUM_W'(shifted);
                alu_b   = SUM_W'(den_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res   = alu_a + (alu_sub ? ~alu_b : alu_b) + SUM_W'(alu_sub);
    assign alu_ge    = ~alu_res[SUM_W-1];
    assign sum_neg   = sum_reg[SUM_W-1];
    assign sum_zero  = (sum_reg == '0);
    assign sum_large = (sum_reg[SUM_W-2:LARGE_BIT] != '0);

    always_comb
    begin
        status_next        = status_reg;
        status_next.done   = 1'b0;
        status_next.update = 1'b0;
        unique case (state_reg)
            U_CHECK:
            begin
                if (count_reg == '0 || sum_neg || sum_zero)
                begin
                    status_next.done = 1'b1;
                end
                else if (sum_large)
                begin
                    status_next.done   = 1'b1;
                    status_next.update = 1'b1;
                    status_next.tempo  = '0;
                end
            end
            U_PRE:
            begin
                if (alu_ge)
                begin
                    status_next.done   = 1'b1;
                    status_next.update = 1'b1;
                    status_next.tempo  = TEMPO_MAX;
                end
            end
            U_DIV:
            begin
                if (step_reg == SW'(TEMPO_W - 1))
                begin
                    status_next.done   = 1'b1;
                    status_next.update = 1'b1;
                    status_next.tempo  = {quo_reg[TEMPO_W-2:0], alu_ge};
                end
            end
            default:
            begin
                status_next.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            cnt_reg    <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
            status_reg <= '0;
        end
        else
        begin
            status_reg <= status_next;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= U_SUM;
                    end
                end
                U_SUM:
                begin
                    if (cnt_reg != '0 && entry != 64'd0)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (cnt_reg == CW'(PULSES_PER_BEAT))
                    begin
                        state_reg <= U_CHECK;
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                end
                U_CHECK:
                begin
                    if (count_reg == '0 || sum_neg || sum_zero || sum_large)
                    begin
                        state_reg <= U_IDLE;
                    end
                    else
                    begin
                        state_reg <= U_MULT;
                    end
                end
                U_MULT:
                begin
                    state_reg <= U_PRE;
                end
                U_PRE:
                begin
                    if (alu_ge)
                    begin
                        state_reg <= U_IDLE;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        state_reg <= U_DIV;
                    end
                end
                U_DIV:
                begin
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(TEMPO_W - 1))
                    begin
                        state_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            U_IDLE:
            begin
                sum_reg <= '0;
            end
            U_SUM:
            begin
                if (cnt_reg != '0)
                begin
                    sum_reg <= alu_res;
                end
            end
            U_MULT:
            begin
                num_reg <= NUM_W'(NUM_SCALE * 64'(count_reg));
                den_reg <= DEN_W'(PULSES_PER_BEAT) * DEN_W'(sum_reg[LARGE_BIT-1:0]);
            end
            U_PRE:
            begin
                rem_reg <= DEN_W'(num_reg[NUM_W-1:TEMPO_W]);
                quo_reg <= num_reg[TEMPO_W-1:0];
            end
            U_DIV:
            begin
                rem_reg <= alu_ge ? alu_res[DEN_W-1:0] : shifted[DEN_W-1:0];
                quo_reg <= {quo_reg[TEMPO_W-2:0], alu_ge};
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

endmodule

// ----- rtl/midi_clock_tempo_tracker.sv -----
// MIDI beat clock tempo tracker.
// Input channel (item, item_valid, item_stall): one MIDI real-time status
// byte with its arrival time in ns. Start zeroes the tick index and sets
// playing, stop clears playing, timing clock logs the interval into a ring of
// PULSES_PER_BEAT entries and recomputes the average tempo.
// Output channel (result, result_valid, result_stall): exactly one result per
// transfer on the input, showing the state after that item.
// Items that do not touch the ring skip the sweep and the divider. A timing
// clock with both timestamps present sweeps the ring via the RAM read port,
// then the restoring divider on the shared adder yields a quotient bit per cycle.
// One item is in flight at a time; item_stall is high from the transfer until
// its result is loaded into the output register. A new item is taken while
// the previous result still waits in that register.
// If result_stall holds the output register full, the next result waits.
// Reset empties the ring (per-entry valid bits), clears the tick index, the
// playing flag and the tempo.
module midi_clock_tempo_tracker #(
    parameter int PULSES_PER_BEAT = mcct_pkg::PULSES_PER_BEAT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mcct_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mcct_pkg::result_t result
);

    import mcct_pkg::*;

    localparam int TW = $clog2(PULSES_PER_BEAT);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_CALC = 3'b010,
        T_EMIT = 3'b100
    } tstate_t;

    tstate_t                    state_reg;
    logic [PULSES_PER_BEAT-1:0] valid_reg;
    logic                       ent_valid_reg;
    logic [TW-1:0]              tick_reg;
    logic [62:0]                prev_reg;
    logic                       run_reg;
    logic [23:0]                tempo_reg;
    logic                       known_reg;
    logic                       acc_reg;
    logic                       result_valid_reg;
    result_t                    result_reg;

    logic [16:0]                dist_lut [PULSES_PER_BEAT];
    logic                       take;
    logic                       is_start;
    logic                       is_stop;
    logic                       is_clock;
    logic                       do_calc;
    logic [63:0]                interval;
    logic [TW-1:0]              rd_addr;
    logic [63:0]                rd_data;
    logic                       emit_ok;
    mcct_tempo_t                unit_status;

    for (genvar g = 0; g < PULSES_PER_BEAT; g++)
    begin : g_dist
        localparam logic [16:0] DIST =
            17'((65536 * (PULSES_PER_BEAT - g)) / PULSES_PER_BEAT);
        assign dist_lut[g] = DIST;
    end

    assign item_stall   = (state_reg != T_IDLE);
    assign take         = item_valid && !item_stall;
    assign is_start     = (item.status_byte == STATUS_START);
    assign is_stop      = (item.status_byte == STATUS_STOP);
    assign is_clock     = (item.status_byte == STATUS_CLOCK);
    assign do_calc      = take && is_clock && (prev_reg != '0) && (item.time_ns != '0);
    assign interval     = {1'b0, item.time_ns} - {1'b0, prev_reg};
    assign emit_ok      = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    mcct_ram #(
        .WIDTH (64),
        .DEPTH (PULSES_PER_BEAT)
    ) u_ring (
        .clk   (clk),
        .we    (do_calc),
        .waddr (tick_reg),
        .wdata (interval),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mcct_tempo_unit #(
        .PULSES_PER_BEAT (PULSES_PER_BEAT)
    ) u_tempo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (do_calc),
        .rd_data  (rd_data),
        .rd_valid (ent_valid_reg),
        .rd_addr  (rd_addr),
        .status   (unit_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            valid_reg        <= '0;
            ent_valid_reg    <= 1'b0;
            tick_reg         <= '0;
            prev_reg         <= '0;
            run_reg          <= 1'b0;
            tempo_reg        <= '0;
            known_reg        <= 1'b0;
            acc_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= valid_reg[rd_addr];
            if (state_reg == T_EMIT && emit_ok)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (take)
                    begin
                        acc_reg   <= is_start || is_stop || is_clock;
                        state_reg <= do_calc ? T_CALC : T_EMIT;
                        if (is_start)
                        begin
                            tick_reg <= '0;
                            run_reg  <= 1'b1;
                        end
                        if (is_stop)
                        begin
                            run_reg <= 1'b0;
                        end
                        if (is_clock)
                        begin
                            tick_reg <= (tick_reg == TW'(PULSES_PER_BEAT - 1)) ?
                                        '0 : tick_reg + TW'(1);
                            prev_reg <= item.time_ns;
                        end
                        if (do_calc)
                        begin
                            valid_reg[tick_reg] <= 1'b1;
                        end
                    end
                end
                T_CALC:
                begin
                    if (unit_status.done)
                    begin
                        if (unit_status.update)
                        begin
                            tempo_reg <= unit_status.tempo;
                            known_reg <= 1'b1;
                        end
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_EMIT && emit_ok)
        begin
            result_reg.accepted          <= acc_reg;
            result_reg.playing           <= run_reg;
            result_reg.tempo_known       <= known_reg;
            result_reg.tempo_q8          <= tempo_reg;
            result_reg.tick_position     <= 5'(tick_reg);
            result_reg.beat_distance_q16 <= dist_lut[tick_reg];
        end
    end

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        unit_status.done |-> state_reg == T_CALC)
        else $error("tempo unit finished outside a calculation");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, tick_reg} < (TW+1)'(PULSES_PER_BEAT))
        else $error("tick index out of range");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg != T_IDLE)
        else $error("transfer did not start an item");

    a_known_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        known_reg |=> known_reg)
        else $error("tempo_known dropped");

endmodule

// ----- test/tb_midi_clock_tempo_tracker.sv -----
module tb_midi_clock_tempo_tracker;
    import mcct_pkg::*;

    localparam int PPB         = PULSES_PER_BEAT_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    class tempo_scoreboard;
        result_t     due_results[$];
        int          errors;
        logic [63:0] intervals[PPB];
        logic [62:0] last_ns;
        int          tick;
        logic        running;
        logic [23:0] tempo;
        logic        known;

        function new();
            errors  = 0;
            last_ns = '0;
            tick    = 0;
            running = 1'b0;
            tempo   = '0;
            known   = 1'b0;
            foreach (intervals[i])
                intervals[i] = '0;
        endfunction

        function void update_tempo();
            logic signed [71:0] total;
            logic [63:0]        quot;
            logic [63:0]        den;
            int                 n;
            total = '0;
            n = 0;
            foreach (intervals[i])
            begin
                if (intervals[i] != 0)
                begin
                    total = total + $signed(intervals[i]);
                    n++;
                end
            end
            if (n == 0 || total <= 0)
                return;
            if (total[71:LARGE_BIT] != 0)
                quot = '0;
            else
            begin
                den  = 64'(PPB) * total[63:0];
                quot = (NUM_SCALE * 64'(n)) / den;
            end
            tempo = (quot > 64'(TEMPO_MAX)) ? TEMPO_MAX : quot[23:0];
            known = 1'b1;
        endfunction

        function void take_status(item_t x);
            result_t r;
            logic    acc;
            acc = 1'b1;
            case (x.status_byte)
                STATUS_START:
                begin
                    tick    = 0;
                    running = 1'b1;
                end
                STATUS_STOP:
                    running = 1'b0;
                STATUS_CLOCK:
                begin
                    if (last_ns != 0 && x.time_ns != 0)
                    begin
                        intervals[tick] = {1'b0, x.time_ns} - {1'b0, last_ns};
                        update_tempo();
                    end
                    tick    = (tick == PPB - 1) ? 0 : tick + 1;
                    last_ns = x.time_ns;
                end
                default:
                    acc = 1'b0;
            endcase
            r.accepted          = acc;
            r.playing           = running;
            r.tempo_known       = known;
            r.tempo_q8          = tempo;
            r.tick_position     = 5'(tick);
            r.beat_distance_q16 = 17'((65536 * (PPB - tick)) / PPB);
            due_results.push_back(r);
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h got %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("playing", want.playing, got.playing);
            check_field("tempo_known", want.tempo_known, got.tempo_known);
            check_field("tempo_q8", want.tempo_q8, got.tempo_q8);
            check_field("tick_position", want.tick_position, got.tick_position);
            check_field("beat_distance_q16", want.beat_distance_q16,
                        got.beat_distance_q16);
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    tempo_scoreboard sb;

    int          cycle_count = 0;
    int          burst_left  = 0;
    int          sent_count  = 0;
    int          stall_left  = 0;
    int          stall_mode  = 0;
    logic [62:0] now_ns      = '0;
    logic [62:0] period;
    int          pick;
    int          run_len;

    midi_clock_tempo_tracker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [62:0] rand63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[62:0];
    endfunction

    task automatic send_item(input logic [7:0] st, input logic [62:0] t);
        item_t x;
        int    gap;
        x.status_byte = st;
        x.time_ns     = t;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= x;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.take_status(x);
        if (st == STATUS_START || st == STATUS_STOP || st == STATUS_CLOCK)
            sent_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                              : $urandom_range(5, 70);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_clock(input logic [62:0] t);
        send_item(STATUS_CLOCK, t);
    endtask

    // receiver back-pressure: modes of free flow, light, even and heavy stalling
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= $urandom_range(0, 1);
            default: result_stall <= ((stall_left % 16) < 12);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        burst_left = $urandom_range(1, 12);
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_item(8'h00, '0);
        send_item(8'hFF, TIME_MAX);
        send_item(8'hF9, 63'd77);
        send_item(STATUS_STOP, 63'd5);
        send_item(STATUS_START, 63'd9);
        send_clock('0);                   // no timestamp at all
        send_clock(63'd1000);             // previous missing
        send_clock(63'd1001);             // 1 ns interval, saturates
        send_clock(63'd1001);             // equal stamps, empty entry
        send_clock(63'd20834334);
        send_clock(63'd5);                // time runs backwards, sum negative
        send_clock('0);
        send_clock(63'd1);
        send_clock(TIME_MAX);             // huge interval, tempo rounds to zero
        send_item(STATUS_STOP, TIME_MAX);
        send_item(8'hFB, TIME_MAX);
        send_item(STATUS_START, '0);
        now_ns = 63'd1000000;
        repeat (6)
        begin
            now_ns = now_ns + 63'd20833333;
            send_clock(now_ns);
        end

        // random
        while (sent_count < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(STATUS_START, rand63());
                period = 63'($urandom_range(2000000, 60000000));
                if ($urandom_range(0, 9) == 0)
                    period = 63'($urandom_range(1, 5000));
                run_len = $urandom_range(5, 60);
                repeat (run_len)
                begin
                    now_ns = now_ns + period + 63'($urandom_range(0, 2000));
                    send_clock(now_ns);
                end
                if ($urandom_range(0, 3) == 0)
                    send_item(STATUS_STOP, rand63());
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: send_item(8'($urandom_range(0, 255)), rand63());
                    1: send_clock('0);
                    2:
                    begin
                        now_ns = rand63();
                        send_clock(now_ns);
                    end
                    3:
                    begin
                        now_ns = now_ns - 63'($urandom_range(1, 100000000));
                        send_clock(now_ns);
                    end
                    4:
                    begin
                        now_ns = now_ns + (rand63() >> $urandom_range(0, 40));
                        send_clock(now_ns);
                    end
                    default: send_clock(now_ns);
                endcase
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
